// ===== rtl/core/cpnc_pkg.sv =====
package cpnc_pkg;

	localparam int SAMPLES    = 16;
	localparam int PIX_W      = 8;
	localparam int SUM_W      = 12;
	localparam int SQ_W       = 20;
	localparam int VAR_W      = 24;
	localparam int PROD_W     = 2 * VAR_W;
	localparam int ITER       = 15;
	localparam int LO_W       = ITER;
	localparam int ACC_W      = 82;
	localparam int RHS_SHIFT  = 30;
	localparam int FRAC_ONE   = 16384;
	localparam int CORR_W     = 16;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	// classified request handed from front to back
	typedef struct packed {
		logic             flat;
		logic             neg;
		logic [VAR_W-1:0] mag;
		logic [VAR_W-1:0] var_a;
		logic [VAR_W-1:0] var_b;
	} cpnc_job_t;

endpackage

// ===== rtl/core/cpnc_if.sv =====
interface cpnc_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] first_pixels_low;
	logic [63:0] first_pixels_high;
	logic [63:0] second_pixels_low;
	logic [63:0] second_pixels_high;

	modport source (output valid, first_pixels_low, first_pixels_high,
		second_pixels_low, second_pixels_high, input ready);
	modport sink (input valid, first_pixels_low, first_pixels_high,
		second_pixels_low, second_pixels_high, output ready);
endinterface

interface cpnc_out_if;
	logic              valid;
	logic              ready;
	logic signed [15:0] correlation;
	logic              flat_patch;

	modport source (output valid, correlation, flat_patch, input ready);
	modport sink (input valid, correlation, flat_patch, output ready);
endinterface

// ===== rtl/core/cpnc_front.sv =====
module cpnc_front
	import cpnc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	cpnc_in_if.sink    in_ch,
	input  logic       q_full,
	output logic       push,
	output cpnc_job_t  job
);

	logic             adv;
	logic             v_s1, v_s2;
	logic [SUM_W-1:0] sa_s1, sb_s1;
	logic [SQ_W-1:0]  qa_s1, qb_s1, dot_s1;
	logic [SUM_W-1:0] sa_c, sb_c;
	logic [SQ_W-1:0]  qa_c, qb_c, dot_c;
	cpnc_job_t        job_s2, job_c;
	logic [VAR_W-1:0] pos_c, negp_c;

	assign adv         = !v_s2 || !q_full;
	assign in_ch.ready = adv;
	assign push        = v_s2 && adv;
	assign job         = job_s2;

	// per-descriptor sums, sums of squares and dot product
	always_comb begin
		logic [PIX_W-1:0]         a, b;
		logic [SAMPLES*PIX_W-1:0] pa, pb;
		pa = {in_ch.first_pixels_high, in_ch.first_pixels_low};
		pb = {in_ch.second_pixels_high, in_ch.second_pixels_low};
		sa_c = '0; sb_c = '0; qa_c = '0; qb_c = '0; dot_c = '0;
		for (int i = 0; i < SAMPLES; i++) begin
			a     = pa[PIX_W*i +: PIX_W];
			b     = pb[PIX_W*i +: PIX_W];
			sa_c  = sa_c + SUM_W'(a);
			sb_c  = sb_c + SUM_W'(b);
			qa_c  = qa_c + SQ_W'(a) * SQ_W'(a);
			qb_c  = qb_c + SQ_W'(b) * SQ_W'(b);
			dot_c = dot_c + SQ_W'(a) * SQ_W'(b);
		end
	end

	// variances and signed numerator
	always_comb begin
		job_c.var_a = {qa_s1, 4'b0} - VAR_W'(sa_s1) * VAR_W'(sa_s1);
		job_c.var_b = {qb_s1, 4'b0} - VAR_W'(sb_s1) * VAR_W'(sb_s1);
		pos_c       = {dot_s1, 4'b0};
		negp_c      = VAR_W'(sa_s1) * VAR_W'(sb_s1);
		job_c.neg   = pos_c < negp_c;
		job_c.mag   = job_c.neg ? negp_c - pos_c : pos_c - negp_c;
		job_c.flat  = (job_c.var_a == '0) || (job_c.var_b == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_ch.valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sa_s1  <= sa_c;
			sb_s1  <= sb_c;
			qa_s1  <= qa_c;
			qb_s1  <= qb_c;
			dot_s1 <= dot_c;
			job_s2 <= job_c;
		end
	end

endmodule

// ===== rtl/core/cpnc_queue.sv =====
module cpnc_queue
	import cpnc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cpnc_job_t wr_job,
	input  logic      pop,
	output cpnc_job_t rd_job,
	output logic      full,
	output logic      empty
);

	cpnc_job_t        mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [CNT_W-1:0] cnt_q;

	assign full   = cnt_q == CNT_W'(FIFO_DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/cpnc_back.sv =====
module cpnc_back
	import cpnc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  cpnc_job_t  job,
	output logic       pop,
	cpnc_out_if.source out_ch
);

	logic adv;
	logic v_b1;
	cpnc_job_t        job_b1;

	logic             v_st    [ITER+1];
	logic [LO_W-1:0]  lo_st   [ITER+1];
	logic [ACC_W-1:0] s_st    [ITER+1];
	logic [ACC_W-1:0] q_st    [ITER+1];
	logic [ACC_W-1:0] prod_st [ITER+1];
	logic [ACC_W-1:0] rhs_st  [ITER+1];
	logic             neg_st  [ITER+1];
	logic             flat_st [ITER+1];

	logic              v_o_q;
	logic signed [CORR_W-1:0] corr_q;
	logic              flat_q;
	logic [CORR_W-1:0] r_c;

	assign adv          = !v_o_q || out_ch.ready;
	assign pop          = adv && !q_empty;
	assign out_ch.valid = v_o_q;
	assign out_ch.correlation = corr_q;
	assign out_ch.flat_patch  = flat_q;

	// stage b1: take request off the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else if (adv) begin
			v_b1 <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			job_b1 <= job;
		end
	end

	// stage 0: variance product and squared numerator, search start at r = 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_st[0] <= 1'b0;
		end else if (adv) begin
			v_st[0] <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		logic [PROD_W-1:0] p, m2;
		p  = PROD_W'(job_b1.var_a) * PROD_W'(job_b1.var_b);
		m2 = PROD_W'(job_b1.mag) * PROD_W'(job_b1.mag);
		if (adv) begin
			lo_st[0]   <= '0;
			s_st[0]    <= ACC_W'(p);
			q_st[0]    <= '0 - ACC_W'(p);
			prod_st[0] <= ACC_W'(p);
			rhs_st[0]  <= ACC_W'(m2) << RHS_SHIFT;
			neg_st[0]  <= job_b1.neg;
			flat_st[0] <= job_b1.flat;
		end
	end

	// one result bit per stage, msb first; s tracks (2r-1)^2*prod, q tracks (2r-1)*prod
	for (genvar i = 0; i < ITER; i++) begin : g_bit
		localparam int K = ITER - 1 - i;
		logic [ACC_W-1:0] cand;
		logic             take;

		assign cand = s_st[i] + (q_st[i] << (K + 2)) + (prod_st[i] << (2 * K + 2));
		assign take = cand <= rhs_st[i];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[i+1] <= 1'b0;
			end else if (adv) begin
				v_st[i+1] <= v_st[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				lo_st[i+1]   <= take ? (lo_st[i] | LO_W'(1 << K)) : lo_st[i];
				s_st[i+1]    <= take ? cand : s_st[i];
				q_st[i+1]    <= take ? q_st[i] + (prod_st[i] << (K + 1)) : q_st[i];
				prod_st[i+1] <= prod_st[i];
				rhs_st[i+1]  <= rhs_st[i];
				neg_st[i+1]  <= neg_st[i];
				flat_st[i+1] <= flat_st[i];
			end
		end
	end

	// clamp to 1.0, apply sign, flat patch forces zero
	always_comb begin
		r_c = (lo_st[ITER] > LO_W'(FRAC_ONE)) ? CORR_W'(FRAC_ONE) : CORR_W'(lo_st[ITER]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_o_q <= 1'b0;
		end else if (adv) begin
			v_o_q <= v_st[ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flat_q <= flat_st[ITER];
			if (flat_st[ITER]) begin
				corr_q <= '0;
			end else begin
				corr_q <= neg_st[ITER] ? -$signed(r_c) : $signed(r_c);
			end
		end
	end

endmodule

// ===== rtl/core/circle_patch_normalized_correlation.sv =====
// channel  | dir | payload                                         | role
// ---------+-----+-------------------------------------------------+--------------------------
// in_ch    | in  | first/second_pixels_low/high, 4 x 64 bits       | two 16-sample descriptors
// out_ch   | out | correlation (s16, 14 frac bits), flat_patch (1) | normalized correlation
//
// one request accepted per cycle unless a full queue stalls the front, one result per request
// path: 2 front stages, queue, 17 back stages, output register
// the 15 bit stages of the back pipeline settle one result bit per stage by shift and add
// arst_n clears all valid bits and the queue pointers; payload registers are not reset
// a stalled output holds the back pipeline; the 4-entry queue lets the front keep going
module circle_patch_normalized_correlation
	import cpnc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	cpnc_in_if.sink    in_ch,
	cpnc_out_if.source out_ch
);

	// front to queue
	logic      push;
	cpnc_job_t push_job;
	// queue to back
	logic      pop;
	cpnc_job_t pop_job;
	logic      q_full, q_empty;

	// sums, variances, numerator and flat detection
	cpnc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.push   (push),
		.job    (push_job)
	);

	// decouples front stalls from back stalls
	cpnc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (push_job),
		.pop    (pop),
		.rd_job (pop_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	// variance product and bitwise rounded ratio search
	cpnc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.job     (pop_job),
		.pop     (pop),
		.out_ch  (out_ch)
	);

endmodule

// ===== tb/circle_patch_normalized_correlation_tb.sv =====
module circle_patch_normalized_correlation_tb;
	import cpnc_pkg::*;

	// descriptor pair as carried by one request
	typedef struct {
		logic [63:0] a_lo;
		logic [63:0] a_hi;
		logic [63:0] b_lo;
		logic [63:0] b_hi;
	} pair_t;

	// expected correlation for one request
	typedef struct {
		logic signed [15:0] corr;
		logic               flat;
	} corr_t;

	// shapes of descriptor pairs for the random part
	typedef enum int {
		PAIR_RANDOM,
		PAIR_ALIKE,
		PAIR_OPPOSITE,
		PAIR_FLAT_A,
		PAIR_FLAT_B,
		PAIR_TWO_LEVEL
	} pair_kind_e;

	class corr_scoreboard;
		corr_t pending[$];
		int    errors;

		function new();
			errors = 0;
		endfunction

		task report(input string msg);
			$display("mismatch: %s", msg);
			errors++;
		endtask

		static function logic [7:0] sample_at(input logic [63:0] lo, input logic [63:0] hi,
				input int idx);
			return (idx < 8) ? lo[8*idx +: 8] : hi[8*(idx-8) +: 8];
		endfunction

		// exact rounding: largest r with (2r-1)^2 * varA*varB <= (2*16384*|num|)^2
		static function corr_t correlate(input pair_t p);
			corr_t       res;
			logic [127:0] sa, sb, qa, qb, dotp, va, vb, pos, ng, mag, prod, scaled, rhs, t;
			logic [127:0] lo, hi, mid;
			logic [7:0]  xa, xb;
			logic        negative;
			sa = 0; sb = 0; qa = 0; qb = 0; dotp = 0;
			for (int i = 0; i < SAMPLES; i++) begin
				xa = sample_at(p.a_lo, p.a_hi, i);
				xb = sample_at(p.b_lo, p.b_hi, i);
				sa += xa;
				sb += xb;
				qa += xa * xa;
				qb += xb * xb;
				dotp += xa * xb;
			end
			va = SAMPLES * qa - sa * sa;
			vb = SAMPLES * qb - sb * sb;
			if (va == 0 || vb == 0) begin
				res.corr = '0;
				res.flat = 1'b1;
				return res;
			end
			pos = SAMPLES * dotp;
			ng = sa * sb;
			negative = pos < ng;
			mag = negative ? ng - pos : pos - ng;
			prod = va * vb;
			scaled = mag * (2 * FRAC_ONE);
			rhs = scaled * scaled;
			lo = 0;
			hi = FRAC_ONE;
			while (lo < hi) begin
				mid = (lo + hi + 1) >> 1;
				t = 2 * mid - 1;
				if (t * t * prod <= rhs) lo = mid;
				else hi = mid - 1;
			end
			res.corr = negative ? -lo[15:0] : lo[15:0];
			res.flat = 1'b0;
			return res;
		endfunction

		function void note_request(input pair_t p);
			pending = {pending, correlate(p)};
		endfunction

		task check_result(input logic signed [15:0] corr, input logic flat);
			corr_t e;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result corr=%0d flat=%0b", corr, flat));
				return;
			end
			e = pending.pop_front();
			if (corr !== e.corr)
				report($sformatf("correlation %0d, expected %0d", corr, e.corr));
			if (flat !== e.flat)
				report($sformatf("flat_patch %0b, expected %0b", flat, e.flat));
		endtask
	endclass

	logic clk;
	logic arst_n;

	cpnc_in_if  in_ch();
	cpnc_out_if out_ch();

	circle_patch_normalized_correlation u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch.sink),
		.out_ch (out_ch.source)
	);

	corr_scoreboard sb;
	int  idle_cycles;
	bit  hold_request;     // sender asks the receiver for one long hold-off
	bit  sender_idles;     // current stretch of the sender uses gaps
	bit  receiver_idles;   // current stretch of the receiver uses stalls

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 80;
	localparam int DRAIN_CYCLES   = 40;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// handshakes are stable between edges, so they are sampled mid-cycle
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_request('{in_ch.first_pixels_low, in_ch.first_pixels_high,
					in_ch.second_pixels_low, in_ch.second_pixels_high});
			if (out_ch.valid && out_ch.ready)
				sb.check_result(out_ch.correlation, out_ch.flat_patch);
		end
	end

	// watchdog: a run of cycles with no handshake on either side ends the run
	always @(negedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !arst_n)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// one request: optional gap, then hold valid until accepted
	task send_pair(input pair_t p);
		int gap;
		gap = sender_idles ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid              <= 1'b1;
		in_ch.first_pixels_low   <= p.a_lo;
		in_ch.first_pixels_high  <= p.a_hi;
		in_ch.second_pixels_low  <= p.b_lo;
		in_ch.second_pixels_high <= p.b_hi;
		do @(negedge clk); while (!in_ch.ready);
		@(posedge clk);
	endtask

	function automatic logic [7:0] clamp_pixel(input int v);
		return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
	endfunction

	function automatic pair_t pack_pair(input logic [7:0] a[16], input logic [7:0] b[16]);
		pair_t p;
		for (int i = 0; i < 8; i++) begin
			p.a_lo[8*i +: 8] = a[i];
			p.a_hi[8*i +: 8] = a[i+8];
			p.b_lo[8*i +: 8] = b[i];
			p.b_hi[8*i +: 8] = b[i+8];
		end
		return p;
	endfunction

	function automatic pair_t make_pair(input pair_kind_e kind);
		logic [7:0] a[16];
		logic [7:0] b[16];
		int noise;
		int lvl_lo, lvl_hi;
		noise = $urandom_range(0, 40);
		lvl_lo = $urandom_range(0, 255);
		lvl_hi = $urandom_range(0, 255);
		for (int i = 0; i < 16; i++) begin
			a[i] = 8'($urandom_range(0, 255));
			b[i] = 8'($urandom_range(0, 255));
		end
		case (kind)
			PAIR_ALIKE: begin
				for (int i = 0; i < 16; i++)
					b[i] = clamp_pixel(a[i] + $urandom_range(0, 2*noise) - noise);
			end
			PAIR_OPPOSITE: begin
				for (int i = 0; i < 16; i++)
					b[i] = clamp_pixel(255 - a[i] + $urandom_range(0, 2*noise) - noise);
			end
			PAIR_FLAT_A: begin
				for (int i = 0; i < 16; i++) a[i] = lvl_lo[7:0];
			end
			PAIR_FLAT_B: begin
				for (int i = 0; i < 16; i++) b[i] = lvl_hi[7:0];
			end
			PAIR_TWO_LEVEL: begin
				for (int i = 0; i < 16; i++) begin
					a[i] = $urandom_range(0, 1) ? lvl_hi[7:0] : lvl_lo[7:0];
					b[i] = $urandom_range(0, 1) ? lvl_hi[7:0] : lvl_lo[7:0];
				end
			end
			default: ;
		endcase
		return pack_pair(a, b);
	endfunction

	// receiver: per-result stall, plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			int stall;
			@(posedge clk);
			if (hold_request) begin
				// long hold-off: the queue fills and the input stalls
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				stall = receiver_idles ? $urandom_range(0, 17) : 0;
				if (stall > 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			do @(negedge clk); while (!out_ch.valid);
		end
	end

	initial begin
		pair_t      p;
		logic [7:0] a[16];
		logic [7:0] b[16];
		int         wait_cycles;
		sb = new();
		idle_cycles = 0;
		hold_request = 1'b0;
		sender_idles = 1'b0;
		receiver_idles = 1'b0;
		in_ch.valid              <= 1'b0;
		in_ch.first_pixels_low   <= '0;
		in_ch.first_pixels_high  <= '0;
		in_ch.second_pixels_low  <= '0;
		in_ch.second_pixels_high <= '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: flat patches at the extremes of the pixel range
		send_pair('{64'h0, 64'h0, 64'h0, 64'h0});
		send_pair('{'1, '1, '1, '1});
		send_pair('{64'h0, 64'h0, 64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00});
		send_pair('{64'h00ff_00ff_00ff_00ff, 64'hff00_ff00_ff00_ff00, '1, '1});
		// full swing checkerboard: identical gives +1.0, inverted gives -1.0
		send_pair('{64'h00ff_00ff_00ff_00ff, 64'h00ff_00ff_00ff_00ff,
			64'h00ff_00ff_00ff_00ff, 64'h00ff_00ff_00ff_00ff});
		send_pair('{64'h00ff_00ff_00ff_00ff, 64'h00ff_00ff_00ff_00ff,
			64'hff00_ff00_ff00_ff00, 64'hff00_ff00_ff00_ff00});
		// single bright sample against one elsewhere, then a faint sample against the same sample
		send_pair('{64'h0000_0000_0000_00ff, 64'h0, 64'h0, 64'hff00_0000_0000_0000});
		send_pair('{64'h0000_0000_0000_0001, 64'h0, 64'h0000_0000_0000_0001, 64'h0});
		// ramps: rising against rising and against falling
		for (int i = 0; i < 16; i++) begin
			a[i] = 8'(i * 17);
			b[i] = 8'(255 - i * 17);
		end
		send_pair(pack_pair(a, a));
		send_pair(pack_pair(a, b));
		// uncorrelated-ish halves
		send_pair('{64'hffff_ffff_ffff_ffff, 64'h0, 64'h00ff_00ff_00ff_00ff,
			64'h00ff_00ff_00ff_00ff});
		for (int k = PAIR_RANDOM; k <= PAIR_TWO_LEVEL; k++)
			send_pair(make_pair(pair_kind_e'(k)));

		// random part, in stretches that switch idling on and off
		for (int n = 0; n < 450; n++) begin
			int pick;
			if (n % 40 == 0) begin
				sender_idles = $urandom_range(0, 2) != 0;
				receiver_idles = $urandom_range(0, 2) != 0;
			end
			if (n == 120) begin
				// receiver holds off while requests keep coming
				sender_idles = 1'b0;
				hold_request = 1'b1;
			end
			if (n == 300) begin
				// pause until the block has drained
				in_ch.valid <= 1'b0;
				wait_cycles = 0;
				while (sb.pending.size() != 0) begin
					@(posedge clk);
					wait_cycles++;
				end
				@(posedge clk);
			end
			pick = $urandom_range(0, 99);
			if (pick < 40) p = make_pair(PAIR_RANDOM);
			else if (pick < 60) p = make_pair(PAIR_ALIKE);
			else if (pick < 78) p = make_pair(PAIR_OPPOSITE);
			else if (pick < 84) p = make_pair(PAIR_FLAT_A);
			else if (pick < 90) p = make_pair(PAIR_FLAT_B);
			else p = make_pair(PAIR_TWO_LEVEL);
			send_pair(p);
		end
		in_ch.valid <= 1'b0;

		// drain; the watchdog covers a result that never comes
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.pending.size()));
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
